@@ rtl/drm_pkg.sv @@
`timescale 1ns / 1ps

package drm_pkg;

  localparam int MAX_RECTS = 32;
  localparam int IDX_W     = $clog2(MAX_RECTS);
  localparam int CNT_W     = $clog2(MAX_RECTS + 1);

  typedef struct packed {
    logic signed [15:0] l;
    logic signed [15:0] t;
    logic signed [15:0] r;
    logic signed [15:0] b;
  } rect_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_O_REQ,
    ST_O_WAIT,
    ST_S_REQ,
    ST_S_CMP,
    ST_E_REQ,
    ST_E_WAIT,
    ST_E_HOLD
  } state_e;

  typedef struct packed {
    logic ld_en;
    logic batch_clr;
    logic o_clr;
    logic o_inc;
    logic i_set;
    logic i_inc;
    logic rd_en;
    logic rd_sel_i;
    logic cur_load;
    logic cmp_step;
    logic wb;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic o_end;
    logic o_alive;
    logic i_end;
    logic i_alive;
    logic out_fire;
  } status_t;

  function automatic logic overlaps(rect_t a, rect_t b);
    return (a.l < b.r) && (b.l < a.r) && (a.t < b.b) && (b.t < a.b);
  endfunction

  function automatic rect_t grow(rect_t a, rect_t b);
    rect_t g;
    g.l = (b.l < a.l) ? b.l : a.l;
    g.t = (b.t < a.t) ? b.t : a.t;
    g.r = (b.r > a.r) ? b.r : a.r;
    g.b = (b.b > a.b) ? b.b : a.b;
    return g;
  endfunction

endpackage

@@ rtl/drm_if.sv @@
`timescale 1ns / 1ps

interface drm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rect_left;
  logic signed [15:0] rect_top;
  logic signed [15:0] rect_right;
  logic signed [15:0] rect_bottom;
  logic               last_rect;

  modport source (
    output valid, rect_left, rect_top, rect_right, rect_bottom, last_rect,
    input  ready
  );
  modport sink (
    input  valid, rect_left, rect_top, rect_right, rect_bottom, last_rect,
    output ready
  );
endinterface

interface drm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_left;
  logic signed [15:0] out_top;
  logic signed [15:0] out_right;
  logic signed [15:0] out_bottom;
  logic               out_last;
  logic               overflow;

  modport source (
    output valid, out_left, out_top, out_right, out_bottom, out_last, overflow,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_top, out_right, out_bottom, out_last, overflow,
    output ready
  );
endinterface

@@ rtl/drm_ctrl.sv @@
`timescale 1ns / 1ps

module drm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  input  drm_pkg::status_t  status_i,
  output logic              in_ready_o,
  output drm_pkg::cmd_t     cmd_o
);

  drm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drm_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drm_pkg::ST_LOAD: begin
        if (in_valid_i && in_last_i) state_d = drm_pkg::ST_O_REQ;
      end
      drm_pkg::ST_O_REQ: begin
        priority if (status_i.o_end) state_d = drm_pkg::ST_E_REQ;
        else if (status_i.o_alive) state_d = drm_pkg::ST_O_WAIT;
        else state_d = drm_pkg::ST_O_REQ;
      end
      drm_pkg::ST_O_WAIT: state_d = drm_pkg::ST_S_REQ;
      drm_pkg::ST_S_REQ: begin
        priority if (status_i.i_end) state_d = drm_pkg::ST_O_REQ;
        else if (status_i.i_alive) state_d = drm_pkg::ST_S_CMP;
        else state_d = drm_pkg::ST_S_REQ;
      end
      drm_pkg::ST_S_CMP: state_d = drm_pkg::ST_S_REQ;
      drm_pkg::ST_E_REQ: begin
        priority if (status_i.o_end) state_d = drm_pkg::ST_LOAD;
        else if (status_i.o_alive) state_d = drm_pkg::ST_E_WAIT;
        else state_d = drm_pkg::ST_E_REQ;
      end
      drm_pkg::ST_E_WAIT: state_d = drm_pkg::ST_E_HOLD;
      drm_pkg::ST_E_HOLD: begin
        if (status_i.out_fire) state_d = drm_pkg::ST_E_REQ;
      end
      default: state_d = drm_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      drm_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_en = 1'b1;
          cmd_o.o_clr = in_last_i;
        end
      end
      drm_pkg::ST_O_REQ: begin
        priority if (status_i.o_end) begin
          cmd_o.o_clr = 1'b1;
        end else if (status_i.o_alive) begin
          cmd_o.rd_en = 1'b1;
        end else begin
          cmd_o.o_inc = 1'b1;
        end
      end
      drm_pkg::ST_O_WAIT: begin
        cmd_o.cur_load = 1'b1;
        cmd_o.i_set    = 1'b1;
      end
      drm_pkg::ST_S_REQ: begin
        priority if (status_i.i_end) begin
          cmd_o.wb    = 1'b1;
          cmd_o.o_inc = 1'b1;
        end else if (status_i.i_alive) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_sel_i = 1'b1;
        end else begin
          cmd_o.i_inc = 1'b1;
        end
      end
      drm_pkg::ST_S_CMP: cmd_o.cmp_step = 1'b1;
      drm_pkg::ST_E_REQ: begin
        priority if (status_i.o_end) begin
          cmd_o.batch_clr = 1'b1;
        end else if (status_i.o_alive) begin
          cmd_o.rd_en = 1'b1;
        end else begin
          cmd_o.o_inc = 1'b1;
        end
      end
      drm_pkg::ST_E_WAIT: cmd_o.out_load = 1'b1;
      drm_pkg::ST_E_HOLD: cmd_o.o_inc = status_i.out_fire;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/drm_dp.sv @@
`timescale 1ns / 1ps

module drm_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drm_pkg::cmd_t     cmd_i,
  input  drm_pkg::rect_t    in_rect_i,
  input  logic              out_ready_i,
  output drm_pkg::status_t  status_o,
  output logic              out_valid_o,
  output drm_pkg::rect_t    out_rect_o,
  output logic              out_last_o,
  output logic              out_ovf_o
);

  localparam int N = drm_pkg::MAX_RECTS;
  localparam int CW = drm_pkg::CNT_W;
  localparam int IW = drm_pkg::IDX_W;

  drm_pkg::rect_t mem [N];
  drm_pkg::rect_t rd_q, cur_q, last_q, out_rect_q;

  logic [CW-1:0] count_q, o_q, i_q;
  logic [N-1:0]  alive_q, above, below_cnt;
  logic          ovf_q, out_valid_q, out_last_q, out_ovf_q;

  logic           full, hit, we, fire;
  logic [IW-1:0]  wa, ra;
  drm_pkg::rect_t wd, fold;

  assign full = (count_q == CW'(N));
  assign hit  = drm_pkg::overlaps(cur_q, rd_q);
  assign fold = drm_pkg::grow(last_q, in_rect_i);
  assign fire = out_valid_q && out_ready_i;

  always_comb begin
    for (int j = 0; j < N; j++) begin
      above[j]     = alive_q[j] && (CW'(j) > o_q);
      below_cnt[j] = (CW'(j) < count_q);
    end
  end

  always_comb begin
    we = cmd_i.ld_en || cmd_i.wb;
    if (cmd_i.wb) begin
      wa = o_q[IW-1:0];
      wd = cur_q;
    end else if (full) begin
      wa = IW'(N - 1);
      wd = fold;
    end else begin
      wa = count_q[IW-1:0];
      wd = in_rect_i;
    end
    ra = cmd_i.rd_sel_i ? i_q[IW-1:0] : o_q[IW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (cmd_i.rd_en) rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_en && (full || (count_q == CW'(N - 1)))) begin
      last_q <= full ? fold : in_rect_i;
    end
    if (cmd_i.cur_load) begin
      cur_q <= rd_q;
    end else if (cmd_i.cmp_step && hit) begin
      cur_q <= drm_pkg::grow(cur_q, rd_q);
    end
    if (cmd_i.out_load) begin
      out_rect_q <= rd_q;
      out_last_q <= ~|above;
      out_ovf_q  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      alive_q     <= '0;
      ovf_q       <= 1'b0;
      o_q         <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.batch_clr) begin
        count_q <= '0;
        alive_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.ld_en) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          alive_q[count_q[IW-1:0]] <= 1'b1;
          count_q <= count_q + CW'(1);
        end
      end else if (cmd_i.cmp_step && hit) begin
        alive_q[i_q[IW-1:0]] <= 1'b0;
      end

      if (cmd_i.o_clr) begin
        o_q <= '0;
      end else if (cmd_i.o_inc) begin
        o_q <= o_q + CW'(1);
      end

      if (cmd_i.i_set || (cmd_i.cmp_step && hit)) begin
        i_q <= o_q + CW'(1);
      end else if (cmd_i.i_inc || cmd_i.cmp_step) begin
        i_q <= i_q + CW'(1);
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.o_end    = (o_q >= count_q);
  assign status_o.o_alive  = alive_q[o_q[IW-1:0]];
  assign status_o.i_end    = (i_q >= count_q);
  assign status_o.i_alive  = alive_q[i_q[IW-1:0]];
  assign status_o.out_fire = fire;

  assign out_valid_o = out_valid_q;
  assign out_rect_o  = out_rect_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(N))
    else $error("entry count beyond capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow flagged with free entries");

  a_alive_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (alive_q & ~below_cnt) == '0)
    else $error("live entry above fill count");

  a_no_load_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_en |-> !out_valid_q)
    else $error("item loaded while result pending");

  a_wb_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wb |-> status_o.i_end && alive_q[o_q[IW-1:0]])
    else $error("write back of dead or unfinished outer entry");

endmodule

@@ rtl/dirty_rect_merge_top.sv @@
`timescale 1ns / 1ps
// Load: one item per cycle, no result until the item flagged last.
// Merge: each live outer entry is scanned against the later live entries, skipping
//   removed ones; a hit grows it and removes the later one; a merge restarts the scan.
// Emit: each live entry is held on the output until the sink takes it; removed ones are skipped.
// Reset (async, active low) clears the fill count, live bits, overflow flag
//   and controller; stored rectangles are undefined until written.

module dirty_rect_merge_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  drm_in_if.sink   in_i,
  drm_out_if.source out_o
);

  drm_pkg::cmd_t    cmd;
  drm_pkg::status_t status;
  drm_pkg::rect_t   in_rect, out_rect;

  assign in_rect.l = in_i.rect_left;
  assign in_rect.t = in_i.rect_top;
  assign in_rect.r = in_i.rect_right;
  assign in_rect.b = in_i.rect_bottom;

  drm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_rect),
    .status_i   (status),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  drm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_rect_i   (in_rect),
    .out_ready_i (out_o.ready),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_rect_o  (out_rect),
    .out_last_o  (out_o.out_last),
    .out_ovf_o   (out_o.overflow)
  );

  assign out_o.out_left   = out_rect.l;
  assign out_o.out_top    = out_rect.t;
  assign out_o.out_right  = out_rect.r;
  assign out_o.out_bottom = out_rect.b;

endmodule
